// ----- design/nsos_pkg.sv -----
// Shared types and constants for the nibble sample overlap segmenter.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package nsos_pkg;

    localparam int RAW_W      = 16;
    localparam int CH_W       = 2;
    localparam int LEVEL_W    = 5;
    localparam int IDX_W      = 7;
    localparam int POS_W      = 16;
    localparam int SLEN_W     = 17;
    localparam int SCNT_W     = 8;
    localparam int STEP_W     = 17;
    localparam int BUMP_W     = 8;
    localparam int SAMPLE_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int COVER_LIMIT = 64;

    localparam logic [SAMPLE_W-1:0] INDEX_LIMIT = 24'hFFFFFF;

    localparam logic [CH_W-1:0]   RST_CHANNEL = 2'd0;
    localparam logic [SLEN_W-1:0] RST_SEG_LEN = 17'd4096;
    localparam logic [SCNT_W-1:0] RST_SEG_CNT = 8'd128;
    localparam logic [STEP_W-1:0] RST_STEP    = 17'd4096;
    localparam logic [BUMP_W-1:0] RST_BUMP    = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL     = 3'd0,
        CFG_SEG_LENGTH  = 3'd1,
        CFG_SEG_COUNT   = 3'd2,
        CFG_MEAN_STEP   = 3'd3,
        CFG_BUMP_PERIOD = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM,
        ST_SCAN,
        ST_FLUSH,
        ST_RETIRE
    } t_state;

    typedef struct packed {
        logic started;
        logic covered;
        logic ends_now;
        logic retire;
    } t_step_flags;

endpackage

`default_nettype wire

// ----- design/nsos_sample_if.sv -----
// Channel interfaces: input sample words and segment results.
// Depends on nsos_pkg for field widths.
`default_nettype none

interface nsos_sample_if;
    logic                         valid;
    logic                         ready;
    logic [nsos_pkg::RAW_W-1:0]   raw_word;

    modport source (output valid, output raw_word, input ready);
    modport sink   (input valid, input raw_word, output ready);
endinterface

interface nsos_result_if;
    logic                                valid;
    logic                                ready;
    logic [nsos_pkg::IDX_W-1:0]          segment_index;
    logic [nsos_pkg::POS_W-1:0]          position;
    logic signed [nsos_pkg::LEVEL_W-1:0] level_half_units;
    logic                                last_of_run;
    logic                                frame_done;

    modport source (output valid, output segment_index, output position,
                    output level_half_units, output last_of_run, output frame_done,
                    input ready);
    modport sink   (input valid, input segment_index, input position,
                    input level_half_units, input last_of_run, input frame_done,
                    output ready);
endinterface

`default_nettype wire

// ----- design/nsos_step_unit.sv -----
// Shared advance and compare unit: steps a segment to its successor start and
// compares a segment's extent against the current sample. Depends on nsos_pkg.
`default_nettype none

module nsos_step_unit #(
    parameter int SEG_W = 8,
    parameter int LEN_W = 17,
    parameter int ST_W  = 25
) (
    input  wire logic [SEG_W-1:0]              i_seg,
    input  wire logic [ST_W-1:0]               i_start,
    input  wire logic [nsos_pkg::BUMP_W-1:0]   i_mod,
    input  wire logic [nsos_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [LEN_W-1:0]              i_len,
    input  wire logic [nsos_pkg::STEP_W-1:0]   i_step,
    input  wire logic [nsos_pkg::BUMP_W-1:0]   i_bump_period,
    output logic [SEG_W-1:0]                   o_seg_nx,
    output logic [ST_W-1:0]                    o_start_nx,
    output logic [nsos_pkg::BUMP_W-1:0]        o_mod_nx,
    output nsos_pkg::t_step_flags              o_flags
);

    localparam int BW    = nsos_pkg::BUMP_W;
    localparam int END_W = ((ST_W > LEN_W) ? ST_W : LEN_W) + 1;

    logic [END_W-1:0] seg_end;
    logic [END_W-1:0] s_ext;
    logic [END_W-1:0] s_plus1;
    logic [BW:0]      mod_inc;
    logic             bump;

    always_comb begin
        seg_end = END_W'(i_start) + END_W'(i_len);
        s_ext   = END_W'(i_sample);
        s_plus1 = s_ext + END_W'(1);

        o_flags.started  = (i_start <= ST_W'(i_sample));
        o_flags.covered  = (seg_end > s_ext);
        o_flags.ends_now = (seg_end == s_plus1);
        o_flags.retire   = (seg_end <= s_plus1);

        mod_inc  = {1'b0, i_mod} + (BW+1)'(1);
        o_mod_nx = (mod_inc == {1'b0, i_bump_period}) ? '0 : mod_inc[BW-1:0];
        bump     = (i_bump_period != '0) && (o_mod_nx == BW'(1));

        o_seg_nx   = i_seg + SEG_W'(1);
        o_start_nx = i_start + ST_W'(i_step) + ST_W'(bump);
    end

endmodule

`default_nettype wire

// ----- design/nsos_rem_unit.sv -----
// Bit-serial remainder unit: segment number modulo bump period, one bit a cycle.
// Depends on nsos_pkg for the period width.
`default_nettype none

module nsos_rem_unit #(
    parameter int SEG_W = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [SEG_W-1:0]            i_dividend,
    input  wire logic [nsos_pkg::BUMP_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [nsos_pkg::BUMP_W-1:0]      o_rem
);

    localparam int BW    = nsos_pkg::BUMP_W;
    localparam int CNT_W = $clog2(SEG_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SEG_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SEG_W-1:0] r_dvd;
    logic [BW-1:0]    r_rem;
    logic [BW:0]      trial;
    logic [BW:0]      n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[SEG_W-1]};
        n_rem = (trial >= {1'b0, i_divisor}) ? (trial - {1'b0, i_divisor}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem[BW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- design/nibble_sample_overlap_segmenter_core.sv -----
// Top level: configuration registers, sequencer, pending and output registers.
// Depends on nsos_pkg, nsos_sample_if, nsos_result_if, nsos_step_unit, nsos_rem_unit.
//
//  port       | dir | transfer on        | payload
//  -----------+-----+--------------------+---------------------------------------------
//  i_sample   | in  | valid && ready     | raw_word
//  o_result   | out | valid && ready     | segment_index, position, level_half_units,
//             |     |                    | last_of_run, frame_done
//  i_cfg_*    | in  | i_cfg_we           | i_cfg_idx selects register, i_cfg_data
//
// Each sample passes through accept, a scan of segments from the oldest on (at most the
// covering ones plus empty ones) with a closing step, a flush, and retiring of ended
// segments with a closing step; each visit is one pass through the shared step unit.
// After a bump_period write, the next sample that does not restart the frame first
// runs the serial remainder unit. Ready is high only when idle. Output stalls hold the
// scan once a second covering segment is found. Reset is synchronous; no clearing pass.
`default_nettype none

module nibble_sample_overlap_segmenter_core #(
    parameter int MAX_SEGMENTS       = 128,
    parameter int MAX_SEGMENT_LENGTH = 65536,
    parameter int MAX_COVER          = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    nsos_sample_if.sink                          i_sample,
    nsos_result_if.source                        o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [nsos_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [nsos_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SEG_W_RAW = $clog2(MAX_SEGMENTS + 1);
    localparam int SEG_W     = (SEG_W_RAW > nsos_pkg::SCNT_W) ? SEG_W_RAW : nsos_pkg::SCNT_W;
    localparam int LEN_W_RAW = $clog2(MAX_SEGMENT_LENGTH + 1);
    localparam int LEN_W     = (LEN_W_RAW > nsos_pkg::SLEN_W) ? LEN_W_RAW : nsos_pkg::SLEN_W;
    localparam int CAP       = (MAX_COVER < nsos_pkg::COVER_LIMIT) ? MAX_COVER
                                                                   : nsos_pkg::COVER_LIMIT;
    localparam int N_W       = $clog2(CAP + 1);
    localparam int ST_W      = SEG_W + nsos_pkg::STEP_W;
    localparam int SW        = nsos_pkg::SAMPLE_W;
    localparam int BW        = nsos_pkg::BUMP_W;
    localparam int IW        = nsos_pkg::IDX_W;
    localparam int PW        = nsos_pkg::POS_W;
    localparam int LW        = nsos_pkg::LEVEL_W;

    localparam logic [SEG_W-1:0] MAX_SEG_V = SEG_W'(MAX_SEGMENTS);
    localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_SEGMENT_LENGTH);
    localparam logic [N_W-1:0]   CAP_V     = N_W'(CAP);

    // configuration
    logic [nsos_pkg::CH_W-1:0]   r_ch;
    logic [nsos_pkg::SLEN_W-1:0] r_slen;
    logic [nsos_pkg::SCNT_W-1:0] r_scnt;
    logic [nsos_pkg::STEP_W-1:0] r_step;
    logic [BW-1:0]               r_bp;

    logic [SEG_W-1:0] eff_cnt;
    logic [LEN_W-1:0] eff_len;

    // frame state
    nsos_pkg::t_state r_state, n_state;
    logic [SW-1:0]    r_s, n_s;
    logic [SEG_W-1:0] r_old_seg, n_old_seg;
    logic [ST_W-1:0]  r_old_start, n_old_start;
    logic [BW-1:0]    r_old_mod, n_old_mod;
    logic             r_stale, n_stale;
    logic signed [LW-1:0] r_level, n_level;

    // scan state
    logic [SEG_W-1:0] r_i, n_i;
    logic [ST_W-1:0]  r_st, n_st;
    logic [BW-1:0]    r_m, n_m;
    logic [N_W-1:0]   r_n, n_n;

    // pending result
    logic          r_pend_v, n_pend_v;
    logic [IW-1:0] r_pend_idx, n_pend_idx;
    logic [PW-1:0] r_pend_pos, n_pend_pos;
    logic          r_pend_fd, n_pend_fd;

    // output register
    logic          r_out_v;
    logic [IW-1:0] r_out_idx, n_out_idx;
    logic [PW-1:0] r_out_pos, n_out_pos;
    logic signed [LW-1:0] r_out_level, n_out_level;
    logic          r_out_last, n_out_last;
    logic          r_out_fd, n_out_fd;
    logic          load_out;
    logic          out_free;

    // shared unit
    logic [SEG_W-1:0]      su_seg, su_seg_nx;
    logic [ST_W-1:0]       su_start, su_start_nx;
    logic [BW-1:0]         su_mod, su_mod_nx;
    nsos_pkg::t_step_flags su_flags;

    logic          rem_start;
    logic          rem_done;
    logic [BW-1:0] rem_val;

    logic [3:0]    nib;
    logic          restart;
    logic [ST_W:0] pos_diff;
    logic          scan_go;
    logic          s_at_limit;
    logic          bp_write;

    always_comb begin
        eff_cnt = (SEG_W'(r_scnt) < MAX_SEG_V) ? SEG_W'(r_scnt) : MAX_SEG_V;
        eff_len = (LEN_W'(r_slen) < MAX_LEN_V) ? LEN_W'(r_slen) : MAX_LEN_V;
    end

    always_comb begin
        if (r_state == nsos_pkg::ST_RETIRE) begin
            su_seg   = r_old_seg;
            su_start = r_old_start;
            su_mod   = r_old_mod;
        end else begin
            su_seg   = r_i;
            su_start = r_st;
            su_mod   = r_m;
        end
    end

    nsos_step_unit #(
        .SEG_W (SEG_W),
        .LEN_W (LEN_W),
        .ST_W  (ST_W)
    ) u_step (
        .i_seg         (su_seg),
        .i_start       (su_start),
        .i_mod         (su_mod),
        .i_sample      (r_s),
        .i_len         (eff_len),
        .i_step        (r_step),
        .i_bump_period (r_bp),
        .o_seg_nx      (su_seg_nx),
        .o_start_nx    (su_start_nx),
        .o_mod_nx      (su_mod_nx),
        .o_flags       (su_flags)
    );

    nsos_rem_unit #(
        .SEG_W (SEG_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_old_seg),
        .i_divisor  (r_bp),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    assign out_free   = !r_out_v || o_result.ready;
    assign nib        = 4'(i_sample.raw_word >> {r_ch, 2'b00});
    assign restart    = (r_old_seg >= eff_cnt);
    assign pos_diff   = (ST_W+1)'(r_s) - (ST_W+1)'(r_st);
    assign scan_go    = (r_i < eff_cnt) && su_flags.started && (r_n < CAP_V);
    assign s_at_limit = (r_s >= nsos_pkg::INDEX_LIMIT);
    assign bp_write   = i_cfg_we
                        && (nsos_pkg::t_cfg_idx'(i_cfg_idx) == nsos_pkg::CFG_BUMP_PERIOD);

    always_comb begin
        n_state     = r_state;
        n_s         = r_s;
        n_old_seg   = r_old_seg;
        n_old_start = r_old_start;
        n_old_mod   = r_old_mod;
        n_stale     = r_stale;
        n_level     = r_level;
        n_i         = r_i;
        n_st        = r_st;
        n_m         = r_m;
        n_n         = r_n;
        n_pend_v    = r_pend_v;
        n_pend_idx  = r_pend_idx;
        n_pend_pos  = r_pend_pos;
        n_pend_fd   = r_pend_fd;
        n_out_idx   = r_out_idx;
        n_out_pos   = r_out_pos;
        n_out_level = r_out_level;
        n_out_last  = r_out_last;
        n_out_fd    = r_out_fd;
        load_out    = 1'b0;
        rem_start   = 1'b0;
        i_sample.ready = 1'b0;

        unique case (r_state)
            nsos_pkg::ST_IDLE: begin
                i_sample.ready = 1'b1;
                if (i_sample.valid) begin
                    n_level  = LW'({nib, 1'b1}) + LW'(16);
                    n_n      = '0;
                    n_pend_v = 1'b0;
                    if (restart) begin
                        n_s         = '0;
                        n_old_seg   = '0;
                        n_old_start = '0;
                        n_old_mod   = '0;
                        n_stale     = 1'b0;
                        n_i         = '0;
                        n_st        = '0;
                        n_m         = '0;
                        n_state     = nsos_pkg::ST_SCAN;
                    end else begin
                        n_i  = r_old_seg;
                        n_st = r_old_start;
                        n_m  = r_old_mod;
                        if (r_stale) begin
                            rem_start = 1'b1;
                            n_state   = nsos_pkg::ST_REM;
                        end else begin
                            n_state = nsos_pkg::ST_SCAN;
                        end
                    end
                end
            end
            nsos_pkg::ST_REM: begin
                if (rem_done) begin
                    n_old_mod = rem_val;
                    n_m       = rem_val;
                    n_stale   = 1'b0;
                    n_state   = nsos_pkg::ST_SCAN;
                end
            end
            nsos_pkg::ST_SCAN: begin
                if (!scan_go) begin
                    n_state = nsos_pkg::ST_FLUSH;
                end else if (!(su_flags.covered && r_pend_v && !out_free)) begin
                    if (su_flags.covered) begin
                        if (r_pend_v) begin
                            load_out    = 1'b1;
                            n_out_idx   = r_pend_idx;
                            n_out_pos   = r_pend_pos;
                            n_out_level = r_level;
                            n_out_last  = 1'b0;
                            n_out_fd    = r_pend_fd;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_idx = r_i[IW-1:0];
                        n_pend_pos = pos_diff[PW-1:0];
                        n_pend_fd  = (su_seg_nx == eff_cnt) && su_flags.ends_now;
                        n_n        = r_n + N_W'(1);
                    end
                    n_i  = su_seg_nx;
                    n_st = su_start_nx;
                    n_m  = su_mod_nx;
                end
            end
            nsos_pkg::ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = nsos_pkg::ST_RETIRE;
                end else if (out_free) begin
                    load_out    = 1'b1;
                    n_out_idx   = r_pend_idx;
                    n_out_pos   = r_pend_pos;
                    n_out_level = r_level;
                    n_out_last  = 1'b1;
                    n_out_fd    = r_pend_fd;
                    n_pend_v    = 1'b0;
                    n_state     = nsos_pkg::ST_RETIRE;
                end
            end
            nsos_pkg::ST_RETIRE: begin
                if ((r_old_seg < eff_cnt) && su_flags.retire) begin
                    n_old_seg   = su_seg_nx;
                    n_old_start = su_start_nx;
                    n_old_mod   = su_mod_nx;
                end else begin
                    if ((r_old_seg >= eff_cnt) || s_at_limit) begin
                        n_s         = '0;
                        n_old_seg   = '0;
                        n_old_start = '0;
                        n_old_mod   = '0;
                        n_stale     = 1'b0;
                    end else begin
                        n_s = r_s + SW'(1);
                    end
                    n_state = nsos_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nsos_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nsos_pkg::ST_IDLE;
            r_s         <= '0;
            r_old_seg   <= '0;
            r_old_start <= '0;
            r_old_mod   <= '0;
            r_stale     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_ch        <= nsos_pkg::RST_CHANNEL;
            r_slen      <= nsos_pkg::RST_SEG_LEN;
            r_scnt      <= nsos_pkg::RST_SEG_CNT;
            r_step      <= nsos_pkg::RST_STEP;
            r_bp        <= nsos_pkg::RST_BUMP;
        end else begin
            r_state     <= n_state;
            r_s         <= n_s;
            r_old_seg   <= n_old_seg;
            r_old_start <= n_old_start;
            r_old_mod   <= n_old_mod;
            r_stale     <= bp_write ? 1'b1 : n_stale;
            r_pend_v    <= n_pend_v;
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (nsos_pkg::t_cfg_idx'(i_cfg_idx))
                    nsos_pkg::CFG_CHANNEL:     r_ch   <= i_cfg_data[nsos_pkg::CH_W-1:0];
                    nsos_pkg::CFG_SEG_LENGTH:  r_slen <= i_cfg_data[nsos_pkg::SLEN_W-1:0];
                    nsos_pkg::CFG_SEG_COUNT:   r_scnt <= i_cfg_data[nsos_pkg::SCNT_W-1:0];
                    nsos_pkg::CFG_MEAN_STEP:   r_step <= i_cfg_data[nsos_pkg::STEP_W-1:0];
                    nsos_pkg::CFG_BUMP_PERIOD: r_bp   <= i_cfg_data[BW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_level     <= n_level;
        r_i         <= n_i;
        r_st        <= n_st;
        r_m         <= n_m;
        r_n         <= n_n;
        r_pend_idx  <= n_pend_idx;
        r_pend_pos  <= n_pend_pos;
        r_pend_fd   <= n_pend_fd;
        r_out_idx   <= n_out_idx;
        r_out_pos   <= n_out_pos;
        r_out_level <= n_out_level;
        r_out_last  <= n_out_last;
        r_out_fd    <= n_out_fd;
    end

    assign o_result.valid            = r_out_v;
    assign o_result.segment_index    = r_out_idx;
    assign o_result.position         = r_out_pos;
    assign o_result.level_half_units = r_out_level;
    assign o_result.last_of_run      = r_out_last;
    assign o_result.frame_done       = r_out_fd;

endmodule

`default_nettype wire

// ----- test/tb_nibble_sample_overlap_segmenter_core.sv -----
// Testbench for nibble_sample_overlap_segmenter_core: drives sample words, checks every segment
// result against a built-in placement predictor, and sweeps the register settings.
// Depends on nsos_pkg, nsos_sample_if and nsos_result_if.
`timescale 1ns / 100ps

module tb_nibble_sample_overlap_segmenter_core;

    localparam int MAX_SEG       = 128;
    localparam int MAX_LEN       = 65536;
    localparam int MAX_COV       = 16;
    localparam int COVER_CAP     = (MAX_COV < nsos_pkg::COVER_LIMIT) ? MAX_COV
                                                                     : nsos_pkg::COVER_LIMIT;
    localparam int SETTLE_CYCLES = 3 + 2 * MAX_SEG + 64;
    localparam int DRAIN_LIMIT   = 200000;

    // index with no register behind it
    localparam logic [nsos_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [nsos_pkg::IDX_W-1:0]          seg;
        logic [nsos_pkg::POS_W-1:0]          pos;
        logic signed [nsos_pkg::LEVEL_W-1:0] level;
        logic                                last;
        logic                                done;
    } t_seg_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [nsos_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [nsos_pkg::CFG_DATA_W-1:0] i_cfg_data;

    nsos_sample_if smp ();
    nsos_result_if res ();

    nibble_sample_overlap_segmenter_core #(
        .MAX_SEGMENTS       (MAX_SEG),
        .MAX_SEGMENT_LENGTH (MAX_LEN),
        .MAX_COVER          (MAX_COV)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp),
        .o_result   (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor copy of the registers and frame state
    logic [nsos_pkg::CH_W-1:0]     reg_channel;
    logic [nsos_pkg::SLEN_W-1:0]   reg_seg_len;
    logic [nsos_pkg::SCNT_W-1:0]   reg_seg_cnt;
    logic [nsos_pkg::STEP_W-1:0]   reg_step;
    logic [nsos_pkg::BUMP_W-1:0]   reg_bump;
    logic [nsos_pkg::SAMPLE_W-1:0] frame_sample;
    int unsigned                   oldest_seg;
    longint unsigned               oldest_begin;

    t_seg_result expected_placements[$];

    int error_count    = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int src_gap_pct    = 0;
    int sink_gap_pct   = 0;
    int sink_hold      = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("** nibble_sample_overlap_segmenter_core: FAILED **");
        $finish;
    end

    function automatic void restart_frame();
        frame_sample = '0;
        oldest_seg   = 0;
        oldest_begin = 0;
    endfunction

    function automatic longint unsigned start_gap(input int unsigned seg);
        int unsigned     bump;
        longint unsigned gap;
        bump = reg_bump;
        gap  = reg_step;
        if (bump != 0 && (seg % bump) == 1)
            gap++;
        return gap;
    endfunction

    function automatic void place_sample(input logic [nsos_pkg::RAW_W-1:0] word);
        int unsigned     len;
        int unsigned     cnt;
        int unsigned     seg;
        int unsigned     n;
        longint unsigned s;
        longint unsigned st;
        longint unsigned pos;
        logic [3:0]      nib;
        t_seg_result     r;
        t_seg_result     held;
        bit              have_held;
        len = (reg_seg_len < MAX_LEN) ? reg_seg_len : MAX_LEN;
        cnt = (reg_seg_cnt < MAX_SEG) ? reg_seg_cnt : MAX_SEG;
        nib = 4'(word >> {reg_channel, 2'b00});
        have_held = 1'b0;
        held = '0;
        if (oldest_seg >= cnt)
            restart_frame();
        s   = frame_sample;
        seg = oldest_seg;
        st  = oldest_begin;
        n   = 0;
        while (seg < cnt && st <= s && n < COVER_CAP) begin
            if (s < st + len) begin
                pos     = s - st;
                r.seg   = nsos_pkg::IDX_W'(seg);
                r.pos   = nsos_pkg::POS_W'(pos);
                r.level = {~nib[3], nib[2:0], 1'b1};
                r.last  = 1'b0;
                r.done  = (seg + 1 == cnt) && (pos + 1 == len);
                if (have_held)
                    expected_placements.push_back(held);
                held = r;
                have_held = 1'b1;
                n++;
            end
            seg++;
            if (seg < cnt)
                st += start_gap(seg);
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_placements.push_back(held);
        end
        // retire segments that end with this sample
        while (oldest_seg < cnt && oldest_begin + len <= s + 1) begin
            oldest_seg++;
            if (oldest_seg < cnt)
                oldest_begin += start_gap(oldest_seg);
        end
        if (oldest_seg >= cnt || frame_sample >= nsos_pkg::INDEX_LIMIT)
            restart_frame();
        else
            frame_sample++;
    endfunction

    function automatic void compare_field(input string name, input integer want,
                                          input integer got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // result side: check each transfer, drive ready
    initial begin
        t_seg_result want;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res.valid && res.ready) begin
                if (expected_placements.size() == 0) begin
                    $error("unexpected result: segment_index %0d position %0d",
                           res.segment_index, res.position);
                    error_count++;
                end else begin
                    want = expected_placements.pop_front();
                    compare_field("segment_index", want.seg, res.segment_index);
                    compare_field("position", want.pos, res.position);
                    compare_field("level_half_units", want.level, res.level_half_units);
                    compare_field("last_of_run", want.last, res.last_of_run);
                    compare_field("frame_done", want.done, res.frame_done);
                    results_seen++;
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(0, 99) >= sink_gap_pct);
            end
        end
    end

    task automatic send_sample(input logic [nsos_pkg::RAW_W-1:0] word);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid    <= 1'b1;
        smp.raw_word <= word;
        @(posedge i_clk);
        while (!smp.ready)
            @(posedge i_clk);
        place_sample(word);
        samples_sent++;
    endtask

    task automatic settle();
        int waited;
        smp.valid <= 1'b0;
        waited = 0;
        while (expected_placements.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_placements.size() != 0) begin
            $error("%0d results never arrived", expected_placements.size());
            error_count++;
            expected_placements.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned ch, input int unsigned len,
                             input int unsigned cnt, input int unsigned step,
                             input int unsigned bump);
        logic [nsos_pkg::CFG_IDX_W-1:0]  idxs[6];
        logic [nsos_pkg::CFG_DATA_W-1:0] vals[6];
        idxs[0] = nsos_pkg::CFG_CHANNEL;     vals[0] = nsos_pkg::CFG_DATA_W'(ch);
        idxs[1] = nsos_pkg::CFG_SEG_LENGTH;  vals[1] = nsos_pkg::CFG_DATA_W'(len);
        idxs[2] = nsos_pkg::CFG_SEG_COUNT;   vals[2] = nsos_pkg::CFG_DATA_W'(cnt);
        idxs[3] = nsos_pkg::CFG_MEAN_STEP;   vals[3] = nsos_pkg::CFG_DATA_W'(step);
        idxs[4] = nsos_pkg::CFG_BUMP_PERIOD; vals[4] = nsos_pkg::CFG_DATA_W'(bump);
        idxs[5] = CFG_UNUSED;                vals[5] = nsos_pkg::CFG_DATA_W'($urandom);
        for (int k = 0; k < 6; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        reg_channel = vals[0][nsos_pkg::CH_W-1:0];
        reg_seg_len = vals[1][nsos_pkg::SLEN_W-1:0];
        reg_seg_cnt = vals[2][nsos_pkg::SCNT_W-1:0];
        reg_step    = vals[3][nsos_pkg::STEP_W-1:0];
        reg_bump    = vals[4][nsos_pkg::BUMP_W-1:0];
        settings_used++;
    endtask

    task automatic test_reset_values();
        send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
    endtask

    task automatic test_channel_levels();
        logic [nsos_pkg::RAW_W-1:0] mask;
        for (int c = 0; c < 4; c++) begin
            configure(c, nsos_pkg::RST_SEG_LEN, nsos_pkg::RST_SEG_CNT, nsos_pkg::RST_STEP,
                      nsos_pkg::RST_BUMP);
            mask = nsos_pkg::RAW_W'(16'hF << (4 * c));
            send_sample(~mask);
            send_sample(mask);
            settle();
        end
    endtask

    task automatic test_clamped_sizes();
        // a zero step starts segments 1 to 127 together, so the cover limit cuts the second run short
        configure(1, 100000, 200, 0, 128);
        send_sample(nsos_pkg::RAW_W'($urandom));
        send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
    endtask

    task automatic test_field_extremes();
        configure(3, MAX_LEN, MAX_SEG, 65536, 128);
        send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
    endtask

    task automatic test_empty_frames();
        configure(0, 4, 0, 1, 0);
        send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
        configure(2, 0, 3, 2, 0);
        repeat (4) send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
    endtask

    task automatic test_gaps();
        configure(1, 2, 2, 3, 0);
        repeat (5) send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
    endtask

    task automatic test_bump_period_one();
        configure(2, 2, 3, 1, 1);
        repeat (4) send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
    endtask

    task automatic test_count_shrink();
        configure(0, 2, 6, 1, 0);
        repeat (3) send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
        // oldest segment now past the new count: frame restarts
        configure(0, 2, 2, 1, 0);
        send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 4; p++) begin
            if (p == 0) begin
                src_gap_pct = 6;  sink_gap_pct = 74;
            end else if (p < 3) begin
                src_gap_pct = 74; sink_gap_pct = 6;
            end else begin
                src_gap_pct = 0;  sink_gap_pct = 0;
            end
            configure($urandom_range(0, 3), $urandom_range(2, 8), $urandom_range(2, 5),
                      $urandom_range(0, 3), $urandom_range(0, 4));
            repeat (12) send_sample(nsos_pkg::RAW_W'($urandom));
            settle();
        end
    endtask

    task automatic test_output_stall();
        configure(2, 30, 40, 1, 0);
        sink_hold = 300;
        repeat (24) send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
        repeat (6) send_sample(nsos_pkg::RAW_W'($urandom));
        settle();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= nsos_pkg::CFG_CHANNEL;
        i_cfg_data   <= '0;
        smp.valid    <= 1'b0;
        smp.raw_word <= '0;
        reg_channel = nsos_pkg::RST_CHANNEL;
        reg_seg_len = nsos_pkg::RST_SEG_LEN;
        reg_seg_cnt = nsos_pkg::RST_SEG_CNT;
        reg_step    = nsos_pkg::RST_STEP;
        reg_bump    = nsos_pkg::RST_BUMP;
        restart_frame();
        src_gap_pct  = 6;
        sink_gap_pct = 74;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_channel_levels();
        test_clamped_sizes();
        test_field_extremes();
        test_empty_frames();
        test_gaps();
        test_bump_period_one();
        test_count_shrink();
        test_random_settings();
        test_output_stall();

        $display("Run covered %0d sample transfers and %0d segment results", samples_sent,
                 results_seen);
        $display("over %0d register settings, with stalls on both channels.", settings_used);
        if (error_count == 0)
            $display("** nibble_sample_overlap_segmenter_core: PASSED **");
        else
            $display("** nibble_sample_overlap_segmenter_core: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
design/nsos_pkg.sv
design/nsos_sample_if.sv
design/nsos_step_unit.sv
design/nsos_rem_unit.sv
design/nibble_sample_overlap_segmenter_core.sv
test/tb_nibble_sample_overlap_segmenter_core.sv
